/* hw/rtl/cft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared constants, command and result types, and a byte class helper.
// ----------------------------------------------------------------------------
package cft_pkg;

  // Field limits of one line.
  localparam int MAX_FIELDS = 16;
  localparam int FIELD_MAX  = 32;

  // Derived widths.
  localparam int FC_W    = $clog2(MAX_FIELDS + 1);
  localparam int LEN_W   = $clog2(FIELD_MAX + 1);
  localparam int HC_W    = $clog2(FIELD_MAX + 2);
  localparam int HOLD_AW = $clog2(FIELD_MAX);
  localparam int IDX_W   = 4;
  localparam int BYTE_W  = 8;

  // Command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE = 1'b1;
  localparam logic [BYTE_W-1:0]    SEP_RESET   = 8'd44;
  localparam logic [BYTE_W-1:0]    QUOTE_RESET = 8'd34;
  localparam logic [BYTE_W-1:0]    NEWLINE     = 8'h0A;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Front parser modes.
  typedef enum logic [4:0] {
    MODE_START  = 5'b00001,
    MODE_UNQ    = 5'b00010,
    MODE_QUO    = 5'b00100,
    MODE_QQ     = 5'b01000,
    MODE_IGNORE = 5'b10000
  } mode_t;

  // Back sequencer states.
  typedef enum logic [2:0] {
    ST_CMD   = 3'b001,
    ST_FLUSH = 3'b010,
    ST_FINAL = 3'b100
  } bstate_t;

  // Command operations.
  typedef enum logic [1:0] {
    OP_TRIM  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_LINE  = 2'd2
  } op_t;

  // One command from the front to the back.
  typedef struct packed {
    op_t               op;
    logic              trim_q;
    logic              trim_b;
    logic              line_end;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // One result item, without its last flag.
  typedef struct packed {
    logic [IDX_W-1:0]  field_index;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              field_done;
    logic              field_overflow;
    logic              line_done;
  } res_t;

  // Step status from the back part to the result stage.
  typedef struct packed {
    logic want;
    logic fire;
    logic endc;
  } step_t;

  // Outcome of one quote-pair filter step.
  typedef struct packed {
    logic              want;
    logic [BYTE_W-1:0] byte_out;
    logic              consume;
    logic              pend;
    logic [LEN_W-1:0]  len;
    logic              ovf;
  } qs_t;

  // Whitespace: tab through carriage return, and space.
  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cft_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/cft_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short register FIFO that decouples the front parser from the back part.
// ----------------------------------------------------------------------------
module cft_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cft_pkg::cmd_t din,
  input  wire logic          pop,
  output cft_pkg::cmd_t      dout,
  output logic               not_empty,
  output logic               full
);

  cft_pkg::cmd_t                   q_r [cft_pkg::CMDQ_DEPTH];
  logic [cft_pkg::CMDQ_AW-1:0]     wp_r, wp_nxt;
  logic [cft_pkg::CMDQ_AW-1:0]     rp_r, rp_nxt;
  logic [cft_pkg::CMDQ_CW-1:0]     cnt_r, cnt_nxt;

  assign dout      = q_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == cft_pkg::CMDQ_CW'(cft_pkg::CMDQ_DEPTH));

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == cft_pkg::CMDQ_AW'(cft_pkg::CMDQ_DEPTH - 1)) ? '0 :
               wp_r + cft_pkg::CMDQ_AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == cft_pkg::CMDQ_AW'(cft_pkg::CMDQ_DEPTH - 1)) ? '0 :
               rp_r + cft_pkg::CMDQ_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + cft_pkg::CMDQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - cft_pkg::CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cft_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front parser
// Accepts line items, tracks the field mode and count, and issues commands.
// ----------------------------------------------------------------------------
module cft_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        kind,
  input  wire logic [cft_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic [cft_pkg::BYTE_W-1:0]  separator_char,
  input  wire logic [cft_pkg::BYTE_W-1:0]  quote_char,
  output logic                             push,
  output cft_pkg::cmd_t                    cmd
);

  cft_pkg::mode_t              mode_r, mode_nxt;
  logic [cft_pkg::FC_W-1:0]    fc_r, fc_nxt;
  logic                        do_close;
  logic                        is_sep;
  logic                        is_quote;

  always_comb begin
    is_sep   = (data_byte == separator_char);
    is_quote = (data_byte == quote_char);
    mode_nxt = mode_r;
    fc_nxt   = fc_r;
    push     = 1'b0;
    do_close = 1'b0;
    cmd.op       = cft_pkg::OP_TRIM;
    cmd.trim_q   = 1'b0;
    cmd.trim_b   = 1'b1;
    cmd.line_end = 1'b0;
    cmd.idx      = cft_pkg::IDX_W'(fc_r);
    cmd.data     = data_byte;

    if (kind == cft_pkg::KIND_EOL) begin
      // End of line closes an open field, or else only reports the line end.
      push = 1'b1;
      if ((mode_r == cft_pkg::MODE_UNQ) || (mode_r == cft_pkg::MODE_QUO) ||
          (mode_r == cft_pkg::MODE_QQ)) begin
        cmd.op       = cft_pkg::OP_CLOSE;
        cmd.line_end = 1'b1;
      end else begin
        cmd.op  = cft_pkg::OP_LINE;
        cmd.idx = '0;
      end
      mode_nxt = cft_pkg::MODE_START;
      fc_nxt   = '0;
    end else begin
      case (mode_r)
        cft_pkg::MODE_START: begin
          if (is_quote) begin
            mode_nxt = cft_pkg::MODE_QUO;
          end else begin
            mode_nxt = cft_pkg::MODE_UNQ;
            push     = 1'b1;
            do_close = is_sep;
          end
        end
        cft_pkg::MODE_UNQ: begin
          push     = 1'b1;
          do_close = is_sep;
        end
        cft_pkg::MODE_QUO: begin
          if (is_quote) begin
            mode_nxt = cft_pkg::MODE_QQ;
          end else begin
            push = 1'b1;
          end
        end
        cft_pkg::MODE_QQ: begin
          push = 1'b1;
          if (is_sep || (data_byte == cft_pkg::NEWLINE)) begin
            do_close = 1'b1;
          end else begin
            // The held quote was content; a new quote starts another pair.
            cmd.trim_q = 1'b1;
            cmd.trim_b = !is_quote;
            mode_nxt   = is_quote ? cft_pkg::MODE_QQ : cft_pkg::MODE_QUO;
          end
        end
        cft_pkg::MODE_IGNORE: begin
          mode_nxt = cft_pkg::MODE_IGNORE;
        end
        default: begin
          mode_nxt = cft_pkg::MODE_IGNORE;
        end
      endcase

      // Field close bookkeeping.
      if (do_close) begin
        cmd.op = cft_pkg::OP_CLOSE;
        fc_nxt = fc_r + cft_pkg::FC_W'(1);
        mode_nxt = (fc_r + cft_pkg::FC_W'(1) >= cft_pkg::FC_W'(cft_pkg::MAX_FIELDS)) ?
                   cft_pkg::MODE_IGNORE : cft_pkg::MODE_START;
      end
    end

    if (!accept) begin
      push     = 1'b0;
      mode_nxt = mode_r;
      fc_nxt   = fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cft_pkg::MODE_START;
      fc_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      fc_r   <= fc_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cft_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back part
// Runs commands: whitespace trim with a hold store, quote-pair removal,
// length cap, field close and line end. At most one result is produced per cycle.
// ----------------------------------------------------------------------------
module cft_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_valid,
  input  wire cft_pkg::cmd_t               cmd,
  input  wire logic [cft_pkg::BYTE_W-1:0]  quote_char,
  input  wire logic [cft_pkg::BYTE_W-1:0]  hold_rdata,
  input  wire logic                        room,
  output logic                             pop,
  output logic                             hold_we,
  output logic [cft_pkg::HOLD_AW-1:0]      hold_waddr,
  output logic [cft_pkg::BYTE_W-1:0]       hold_wdata,
  output logic [cft_pkg::HOLD_AW-1:0]      hold_raddr,
  output cft_pkg::step_t                   ev,
  output cft_pkg::res_t                    res
);

  cft_pkg::bstate_t               state_r, state_nxt;
  logic                           qdone_r, qdone_nxt;
  logic                           started_r, started_nxt;
  logic                           pending_r, pending_nxt;
  logic [cft_pkg::HC_W-1:0]       hcount_r, hcount_nxt;
  logic [cft_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [cft_pkg::HOLD_AW-1:0]    fidx_r, fidx_nxt;

  logic [cft_pkg::BYTE_W-1:0]     x;
  logic [cft_pkg::BYTE_W-1:0]     y;
  cft_pkg::qs_t                   qs;
  logic [cft_pkg::HC_W-1:0]       hold_n;
  logic                           flush_last;
  logic                           step;
  logic                           want;
  logic                           endc;
  logic                           fire;
  logic                           trim_done;
  logic                           clear;

  // One step of the quote-pair filter on byte b, with the length cap.
  function automatic cft_pkg::qs_t quote_step(
    input logic [cft_pkg::BYTE_W-1:0] b,
    input logic [cft_pkg::BYTE_W-1:0] q,
    input logic                       pend,
    input logic [cft_pkg::LEN_W-1:0]  len,
    input logic                       ovf
  );
    cft_pkg::qs_t r;
    logic [cft_pkg::BYTE_W-1:0] v;
    logic put;
    r.want     = 1'b0;
    r.byte_out = '0;
    r.consume  = 1'b1;
    r.pend     = pend;
    r.len      = len;
    r.ovf      = ovf;
    v   = b;
    put = 1'b0;
    if (pend) begin
      r.pend = 1'b0;
      if (b != q) begin
        // A lone quote is content; the byte itself is retried next step.
        v         = q;
        put       = 1'b1;
        r.consume = 1'b0;
      end
    end else if (b == q) begin
      r.pend = 1'b1;
    end else begin
      put = 1'b1;
    end
    if (put) begin
      if (len < cft_pkg::LEN_W'(cft_pkg::FIELD_MAX)) begin
        r.want     = 1'b1;
        r.byte_out = v;
        r.len      = len + cft_pkg::LEN_W'(1);
      end else begin
        r.ovf = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    x = (cmd.trim_q && !qdone_r) ? quote_char : cmd.data;
    y = (state_r == cft_pkg::ST_FLUSH) ? hold_rdata : x;
    qs = quote_step(y, quote_char, pending_r, len_r, ovf_r);
    hold_n = (hcount_r > cft_pkg::HC_W'(cft_pkg::FIELD_MAX)) ?
             cft_pkg::HC_W'(cft_pkg::FIELD_MAX) : hcount_r;
    flush_last = ((cft_pkg::HC_W'(fidx_r) + cft_pkg::HC_W'(1)) == hold_n);

    state_nxt   = state_r;
    qdone_nxt   = qdone_r;
    started_nxt = started_r;
    pending_nxt = pending_r;
    hcount_nxt  = hcount_r;
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    fidx_nxt    = fidx_r;
    step      = 1'b0;
    want      = 1'b0;
    endc      = 1'b0;
    pop       = 1'b0;
    hold_we   = 1'b0;
    trim_done = 1'b0;
    clear     = 1'b0;
    res.field_index    = cmd.idx;
    res.out_byte       = '0;
    res.byte_valid     = 1'b0;
    res.field_done     = 1'b0;
    res.field_overflow = 1'b0;
    res.line_done      = 1'b0;

    case (state_r)
      cft_pkg::ST_CMD: begin
        if (cmd_valid) begin
          step = 1'b1;
          case (cmd.op)
            cft_pkg::OP_LINE: begin
              want          = 1'b1;
              res.line_done = 1'b1;
              endc          = 1'b1;
              pop           = 1'b1;
              clear         = 1'b1;
            end
            cft_pkg::OP_CLOSE: begin
              // Trailing whitespace is dropped; a pending quote goes out first.
              hcount_nxt = '0;
              if (pending_r) begin
                pending_nxt = 1'b0;
                if (len_r < cft_pkg::LEN_W'(cft_pkg::FIELD_MAX)) begin
                  want           = 1'b1;
                  res.out_byte   = quote_char;
                  res.byte_valid = 1'b1;
                  len_nxt        = len_r + cft_pkg::LEN_W'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end else begin
                want               = 1'b1;
                res.field_done     = 1'b1;
                res.field_overflow = ovf_r;
                res.line_done      = cmd.line_end;
                endc               = 1'b1;
                pop                = 1'b1;
                clear              = 1'b1;
              end
            end
            cft_pkg::OP_TRIM: begin
              if (cft_pkg::is_ws(x)) begin
                // Whitespace after content is held until it proves inner.
                if (started_r) begin
                  if (hcount_r < cft_pkg::HC_W'(cft_pkg::FIELD_MAX)) begin
                    hold_we    = 1'b1;
                    hcount_nxt = hcount_r + cft_pkg::HC_W'(1);
                  end else begin
                    hcount_nxt = cft_pkg::HC_W'(cft_pkg::FIELD_MAX + 1);
                  end
                end
                trim_done = 1'b1;
              end else if (hcount_r != '0) begin
                state_nxt = cft_pkg::ST_FLUSH;
              end else begin
                started_nxt    = 1'b1;
                want           = qs.want;
                res.out_byte   = qs.byte_out;
                res.byte_valid = qs.want;
                pending_nxt    = qs.pend;
                len_nxt        = qs.len;
                ovf_nxt        = qs.ovf;
                if (qs.consume) begin
                  trim_done = 1'b1;
                end else begin
                  state_nxt = cft_pkg::ST_FINAL;
                end
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      cft_pkg::ST_FLUSH: begin
        // Held whitespace goes through the quote filter, one byte a step.
        step           = 1'b1;
        want           = qs.want;
        res.out_byte   = qs.byte_out;
        res.byte_valid = qs.want;
        pending_nxt    = qs.pend;
        len_nxt        = qs.len;
        ovf_nxt        = qs.ovf;
        if (qs.consume) begin
          if (flush_last) begin
            ovf_nxt = qs.ovf |
                      (hcount_r > cft_pkg::HC_W'(cft_pkg::FIELD_MAX));
            hcount_nxt  = '0;
            started_nxt = 1'b1;
            fidx_nxt    = '0;
            state_nxt   = cft_pkg::ST_FINAL;
          end else begin
            fidx_nxt = fidx_r + cft_pkg::HOLD_AW'(1);
          end
        end
      end
      cft_pkg::ST_FINAL: begin
        step           = 1'b1;
        want           = qs.want;
        res.out_byte   = qs.byte_out;
        res.byte_valid = qs.want;
        pending_nxt    = qs.pend;
        len_nxt        = qs.len;
        ovf_nxt        = qs.ovf;
        if (qs.consume) begin
          trim_done = 1'b1;
          state_nxt = cft_pkg::ST_CMD;
        end
      end
      default: begin
        state_nxt = cft_pkg::ST_CMD;
      end
    endcase

    // A trim finished: either the second byte of the command follows, or it ends.
    if (trim_done) begin
      if (cmd.trim_q && !qdone_r && cmd.trim_b) begin
        qdone_nxt = 1'b1;
      end else begin
        qdone_nxt = 1'b0;
        pop       = 1'b1;
        endc      = 1'b1;
      end
    end

    // Field state is cleared after a close or a line end.
    if (clear) begin
      started_nxt = 1'b0;
      pending_nxt = 1'b0;
      hcount_nxt  = '0;
      len_nxt     = '0;
      ovf_nxt     = 1'b0;
      qdone_nxt   = 1'b0;
    end

    // Hold everything while the result stage has no room.
    fire = step && (!want || room);
    if (!fire) begin
      state_nxt   = state_r;
      qdone_nxt   = qdone_r;
      started_nxt = started_r;
      pending_nxt = pending_r;
      hcount_nxt  = hcount_r;
      len_nxt     = len_r;
      ovf_nxt     = ovf_r;
      fidx_nxt    = fidx_r;
      pop         = 1'b0;
      hold_we     = 1'b0;
    end

    ev.want = want;
    ev.fire = fire;
    ev.endc = endc;
    hold_waddr = hcount_r[cft_pkg::HOLD_AW-1:0];
    hold_wdata = x;
    hold_raddr = fidx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cft_pkg::ST_CMD;
      qdone_r   <= 1'b0;
      started_r <= 1'b0;
      pending_r <= 1'b0;
      hcount_r  <= '0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      fidx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      qdone_r   <= qdone_nxt;
      started_r <= started_nxt;
      pending_r <= pending_nxt;
      hcount_r  <= hcount_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      fidx_r    <= fidx_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cft_result_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result stage
// Holds each result until the next one or the command end shows whether it
// is the last of its item, then passes it to the output register.
// ----------------------------------------------------------------------------
module cft_result_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cft_pkg::step_t ev,
  input  wire cft_pkg::res_t  res,
  input  wire logic           out_stall,
  output logic                room,
  output logic                out_valid,
  output cft_pkg::res_t       out_res,
  output logic                out_last
);

  logic          pend_valid_r, pend_valid_nxt;
  logic          pend_end_r, pend_end_nxt;
  cft_pkg::res_t pend_r;
  logic          out_valid_r, out_valid_nxt;
  cft_pkg::res_t out_r;
  logic          out_last_r;
  logic          out_free;
  logic          pend_leave;
  logic          take;

  always_comb begin
    out_free   = !out_valid_r || !out_stall;
    // The held result leaves once its successor or its command end is known.
    pend_leave = pend_valid_r && out_free && (pend_end_r || ev.want);
    room       = !pend_valid_r || pend_leave;
    take       = ev.fire && ev.want;

    pend_valid_nxt = take ? 1'b1 : (pend_leave ? 1'b0 : pend_valid_r);
    if (take) begin
      pend_end_nxt = ev.endc;
    end else if (ev.fire && ev.endc) begin
      pend_end_nxt = 1'b1;
    end else begin
      pend_end_nxt = pend_end_r;
    end

    out_valid_nxt = pend_leave ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_end_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_end_r   <= pend_end_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= res;
    end
    if (pend_leave) begin
      out_r      <= pend_r;
      out_last_r <= pend_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

/* hw/rtl/csv_field_tokenizer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// One byte item per cycle while the command queue has space; a non-whitespace
// byte after held whitespace first replays the held bytes, one hold store read
// each, and a held quote released as content, or a quote and a byte carried by
// one item, adds a step each. One result leaves per cycle while out_stall is
// low. Reset clears all control state and sets comma and double quote; the hold
// store needs no clearing pass.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_kind,
  input  wire logic [cft_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [cft_pkg::IDX_W-1:0]           out_field_index,
  output logic [cft_pkg::BYTE_W-1:0]          out_out_byte,
  output logic                                out_byte_valid,
  output logic                                out_field_done,
  output logic                                out_field_overflow,
  output logic                                out_line_done,
  output logic                                out_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cft_pkg::BYTE_W-1:0]     cfg_data
);

  logic [cft_pkg::BYTE_W-1:0]  sep_r;
  logic [cft_pkg::BYTE_W-1:0]  quote_r;
  logic                        in_accept;
  logic                        push;
  cft_pkg::cmd_t               push_cmd;
  cft_pkg::cmd_t               head_cmd;
  logic                        q_not_empty;
  logic                        q_full;
  logic                        pop;
  logic                        hold_we;
  logic [cft_pkg::HOLD_AW-1:0] hold_waddr;
  logic [cft_pkg::BYTE_W-1:0]  hold_wdata;
  logic [cft_pkg::HOLD_AW-1:0] hold_raddr;
  logic [cft_pkg::BYTE_W-1:0]  hold_rdata;
  cft_pkg::step_t              ev;
  cft_pkg::res_t               res;
  logic                        room;
  cft_pkg::res_t               out_res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= cft_pkg::SEP_RESET;
      quote_r <= cft_pkg::QUOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cft_pkg::REG_SEP:   sep_r   <= cfg_data;
        cft_pkg::REG_QUOTE: quote_r <= cfg_data;
        default: begin
          sep_r <= sep_r;
        end
      endcase
    end
  end

  // Input handshake: items are taken while the command queue has space.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  cft_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .kind           (in_kind),
    .data_byte      (in_data_byte),
    .separator_char (sep_r),
    .quote_char     (quote_r),
    .push           (push),
    .cmd            (push_cmd)
  );

  cft_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (push_cmd),
    .pop       (pop),
    .dout      (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cft_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (head_cmd),
    .quote_char (quote_r),
    .hold_rdata (hold_rdata),
    .room       (room),
    .pop        (pop),
    .hold_we    (hold_we),
    .hold_waddr (hold_waddr),
    .hold_wdata (hold_wdata),
    .hold_raddr (hold_raddr),
    .ev         (ev),
    .res        (res)
  );

  // Whitespace hold store.
  cft_ram #(
    .WIDTH (cft_pkg::BYTE_W),
    .DEPTH (cft_pkg::FIELD_MAX)
  ) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hold_waddr),
    .wdata (hold_wdata),
    .raddr (hold_raddr),
    .rdata (hold_rdata)
  );

  cft_result_stage u_result_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .res       (res),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign out_field_index    = out_res.field_index;
  assign out_out_byte       = out_res.out_byte;
  assign out_byte_valid     = out_res.byte_valid;
  assign out_field_done     = out_res.field_done;
  assign out_field_overflow = out_res.field_overflow;
  assign out_line_done      = out_res.line_done;

endmodule
`default_nettype wire

/* tb/sv/tb_csv_field_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer core testbench
// Feeds text lines byte by byte, each closed by an end-of-line item, and
// checks every result against an in-bench tokenizer that tracks quoting,
// trimming, quote pairs, field cuts and the field cap. Runs directed lines,
// overlong fields, the field cap, several delimiter settings, random idle
// and stall mixes, a long output hold-off and random noise lines.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer_core;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_STRETCH  = 300;
  localparam int SETTLE_CYCLES = 8;

  // One result item as the tokenizer should produce it.
  typedef struct packed {
    logic [cft_pkg::IDX_W-1:0]  idx;
    logic [cft_pkg::BYTE_W-1:0] data;
    logic                       valid;
    logic                       done;
    logic                       ovf;
    logic                       line;
    logic                       last;
  } token_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_kind = cft_pkg::KIND_BYTE;
  logic [cft_pkg::BYTE_W-1:0]    in_data_byte = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index = cft_pkg::REG_SEP;
  logic [cft_pkg::BYTE_W-1:0]    cfg_data = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic [cft_pkg::IDX_W-1:0]     out_field_index;
  logic [cft_pkg::BYTE_W-1:0]    out_out_byte;
  logic                          out_byte_valid;
  logic                          out_field_done;
  logic                          out_field_overflow;
  logic                          out_line_done;
  logic                          out_last;
  logic                          cfg_ready;

  csv_field_tokenizer_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_field_index    (out_field_index),
    .out_out_byte       (out_out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_field_done     (out_field_done),
    .out_field_overflow (out_field_overflow),
    .out_line_done      (out_line_done),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tokenizer state mirrored in the bench.
  logic [cft_pkg::BYTE_W-1:0] sep_byte;
  logic [cft_pkg::BYTE_W-1:0] quote_byte;
  cft_pkg::mode_t             tok_mode;
  logic [cft_pkg::FC_W-1:0]   tok_fields;
  logic                       tok_started;
  logic                       quote_held;
  logic                       tok_cut;
  logic [cft_pkg::BYTE_W-1:0] blank_hold [cft_pkg::FIELD_MAX];
  int unsigned                blank_cnt;
  int unsigned                tok_len;
  token_t                     step_tokens[$];
  token_t                     expected_tokens[$];

  // Stimulus shaping and bookkeeping.
  logic [cft_pkg::BYTE_W-1:0] line_q[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       hold_req = 0;
  int unsigned       hold_left = 0;
  int unsigned       items_sent = 0;
  int unsigned       lines_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       cfg_writes = 0;
  int unsigned       mismatches = 0;

  function automatic logic is_blank(input logic [cft_pkg::BYTE_W-1:0] ch);
    case (ch)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit_token(input logic [cft_pkg::IDX_W-1:0] idx,
                                     input logic [cft_pkg::BYTE_W-1:0] ch,
                                     input logic valid, input logic done,
                                     input logic ovf, input logic line);
    token_t t;
    t.idx   = idx;
    t.data  = ch;
    t.valid = valid;
    t.done  = done;
    t.ovf   = ovf;
    t.line  = line;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_field();
    tok_started = 1'b0;
    quote_held  = 1'b0;
    blank_cnt   = 0;
    tok_len     = 0;
    tok_cut     = 1'b0;
  endfunction

  function automatic void reset_tokenizer();
    sep_byte   = cft_pkg::SEP_RESET;
    quote_byte = cft_pkg::QUOTE_RESET;
    tok_mode   = cft_pkg::MODE_START;
    tok_fields = '0;
    clear_field();
  endfunction

  // Content bytes past the field limit are dropped and remembered as a cut.
  function automatic void put_content(input logic [cft_pkg::BYTE_W-1:0] ch);
    if (tok_len < cft_pkg::FIELD_MAX) begin
      emit_token(tok_fields[cft_pkg::IDX_W-1:0], ch, 1'b1, 1'b0, 1'b0, 1'b0);
      tok_len++;
    end else begin
      tok_cut = 1'b1;
    end
  endfunction

  // A quote waits for the next byte: a second quote drops both.
  function automatic void quote_filter(input logic [cft_pkg::BYTE_W-1:0] ch);
    if (quote_held) begin
      quote_held = 1'b0;
      if (ch == quote_byte) return;
      put_content(quote_byte);
    end
    if (ch == quote_byte) quote_held = 1'b1;
    else put_content(ch);
  endfunction

  // Leading blanks vanish; inner blanks are held until a non-blank follows.
  function automatic void trim_filter(input logic [cft_pkg::BYTE_W-1:0] ch);
    int unsigned n;
    if (is_blank(ch)) begin
      if (tok_started) begin
        if (blank_cnt < cft_pkg::FIELD_MAX) begin
          blank_hold[blank_cnt] = ch;
          blank_cnt++;
        end else begin
          blank_cnt = cft_pkg::FIELD_MAX + 1;
        end
      end
      return;
    end
    n = (blank_cnt < cft_pkg::FIELD_MAX) ? blank_cnt : cft_pkg::FIELD_MAX;
    for (int i = 0; i < n; i++) quote_filter(blank_hold[i]);
    if (blank_cnt > cft_pkg::FIELD_MAX) tok_cut = 1'b1;
    blank_cnt   = 0;
    tok_started = 1'b1;
    quote_filter(ch);
  endfunction

  function automatic void close_field(input logic line_end);
    blank_cnt = 0;
    if (quote_held) begin
      quote_held = 1'b0;
      put_content(quote_byte);
    end
    emit_token(tok_fields[cft_pkg::IDX_W-1:0], '0, 1'b0, 1'b1, tok_cut, line_end);
    tok_fields++;
    clear_field();
    tok_mode = (tok_fields >= cft_pkg::MAX_FIELDS) ? cft_pkg::MODE_IGNORE :
               cft_pkg::MODE_START;
  endfunction

  // Work out the results of one accepted item and queue them.
  function automatic void tokenize_item(input logic kind,
                                        input logic [cft_pkg::BYTE_W-1:0] ch);
    token_t t;
    step_tokens.delete();
    if (kind == cft_pkg::KIND_EOL) begin
      if (tok_mode == cft_pkg::MODE_UNQ || tok_mode == cft_pkg::MODE_QUO ||
          tok_mode == cft_pkg::MODE_QQ) begin
        close_field(1'b1);
      end else begin
        emit_token('0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      tok_mode   = cft_pkg::MODE_START;
      tok_fields = '0;
      clear_field();
    end else begin
      case (tok_mode)
        cft_pkg::MODE_START: begin
          if (ch == quote_byte) begin
            tok_mode = cft_pkg::MODE_QUO;
          end else begin
            tok_mode = cft_pkg::MODE_UNQ;
            if (ch == sep_byte) close_field(1'b0);
            else trim_filter(ch);
          end
        end
        cft_pkg::MODE_UNQ: begin
          if (ch == sep_byte) close_field(1'b0);
          else trim_filter(ch);
        end
        cft_pkg::MODE_QUO: begin
          if (ch == quote_byte) tok_mode = cft_pkg::MODE_QQ;
          else trim_filter(ch);
        end
        cft_pkg::MODE_QQ: begin
          // A quote not followed by a field end is content after all.
          if (ch == sep_byte || ch == cft_pkg::NEWLINE) begin
            close_field(1'b0);
          end else begin
            tok_mode = cft_pkg::MODE_QUO;
            trim_filter(quote_byte);
            if (ch == quote_byte) tok_mode = cft_pkg::MODE_QQ;
            else trim_filter(ch);
          end
        end
        default: tok_mode = cft_pkg::MODE_IGNORE;
      endcase
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // Compare one result with the oldest expected token, field by field.
  task automatic check_token(input token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected result field %0d byte %02h",
                                got.idx, got.data));
      return;
    end
    want = expected_tokens.pop_front();
    results_seen++;
    if (got.idx !== want.idx)
      report_mismatch($sformatf("result %0d field_index %0d, want %0d",
                                results_seen, got.idx, want.idx));
    if (got.data !== want.data)
      report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                results_seen, got.data, want.data));
    if (got.valid !== want.valid)
      report_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                results_seen, got.valid, want.valid));
    if (got.done !== want.done)
      report_mismatch($sformatf("result %0d field_done %b, want %b",
                                results_seen, got.done, want.done));
    if (got.ovf !== want.ovf)
      report_mismatch($sformatf("result %0d field_overflow %b, want %b",
                                results_seen, got.ovf, want.ovf));
    if (got.line !== want.line)
      report_mismatch($sformatf("result %0d line_done %b, want %b",
                                results_seen, got.line, want.line));
    if (got.last !== want.last)
      report_mismatch($sformatf("result %0d last %b, want %b",
                                results_seen, got.last, want.last));
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_token({out_field_index, out_out_byte, out_byte_valid, out_field_done,
                   out_field_overflow, out_line_done, out_last});
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_tokens.size());
    $display("tb_csv_field_tokenizer_core: FAIL");
    $finish;
  end

  // Offer one item, with random idle cycles first, and wait for it to be taken.
  task automatic send_item(input logic kind, input logic [cft_pkg::BYTE_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_item(kind, ch);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(cft_pkg::KIND_BYTE, line_q[i]);
    send_item(cft_pkg::KIND_EOL, 8'($urandom_range(255)));
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both delimiter registers back to back; only called while idle.
  task automatic set_delimiters(input logic [cft_pkg::BYTE_W-1:0] sep,
                                input logic [cft_pkg::BYTE_W-1:0] quo);
    cfg_valid <= 1'b1;
    cfg_index <= cft_pkg::REG_SEP;
    cfg_data  <= sep;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sep_byte  = sep;
    cfg_index <= cft_pkg::REG_QUOTE;
    cfg_data  <= quo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    quote_byte = quo;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
    @(posedge clk);
  endtask

  function automatic logic [cft_pkg::BYTE_W-1:0] pick_blank();
    logic [cft_pkg::BYTE_W-1:0] ch;
    do begin
      ch = ($urandom_range(2) == 0) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
    end while (ch == sep_byte);
    return ch;
  endfunction

  function automatic logic [cft_pkg::BYTE_W-1:0] pick_content();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 8'h61 + 8'($urandom_range(25));
    if (r < 55) return pick_blank();
    if (r < 65) return quote_byte;
    return 8'($urandom_range(255));
  endfunction

  // Unquoted field: no separator inside and no quote as its first byte.
  function automatic void add_unquoted(input int unsigned len, input int unsigned pad);
    int unsigned first;
    logic [cft_pkg::BYTE_W-1:0] ch;
    first = line_q.size();
    repeat (pad) line_q.push_back(pick_blank());
    repeat (len) begin
      do begin
        ch = pick_content();
      end while (ch == sep_byte || (line_q.size() == first && ch == quote_byte));
      line_q.push_back(ch);
    end
    repeat (pad) line_q.push_back(pick_blank());
  endfunction

  // Quoted field: inner quotes mostly doubled, sometimes closed by a newline.
  function automatic void add_quoted(input int unsigned len, input int unsigned pad,
                                     input logic at_end);
    logic [cft_pkg::BYTE_W-1:0] ch;
    line_q.push_back(quote_byte);
    repeat (pad) line_q.push_back(pick_blank());
    repeat (len) begin
      ch = pick_content();
      line_q.push_back(ch);
      if (ch == quote_byte && $urandom_range(3) != 0) line_q.push_back(ch);
    end
    repeat (pad) line_q.push_back(pick_blank());
    line_q.push_back(quote_byte);
    if (at_end && $urandom_range(2) == 0) line_q.push_back(cft_pkg::NEWLINE);
  endfunction

  function automatic void build_random_line(input int unsigned max_fields);
    int unsigned nf;
    nf = $urandom_range(max_fields);
    line_q.delete();
    for (int f = 0; f < nf; f++) begin
      if (f != 0) line_q.push_back(sep_byte);
      case ($urandom_range(5))
        0: ;
        1, 2: add_unquoted($urandom_range(1, 5), $urandom_range(2));
        default: add_quoted($urandom_range(5), $urandom_range(2), f == nf - 1);
      endcase
    end
    if (nf != 0 && $urandom_range(4) == 0) line_q.push_back(sep_byte);
  endfunction

  // Noise: bytes biased toward delimiters, newlines and blanks.
  function automatic void build_noise_line();
    int unsigned r;
    line_q.delete();
    repeat ($urandom_range(10)) begin
      r = $urandom_range(99);
      if (r < 30) line_q.push_back(sep_byte);
      else if (r < 50) line_q.push_back(quote_byte);
      else if (r < 60) line_q.push_back(cft_pkg::NEWLINE);
      else if (r < 75) line_q.push_back(pick_blank());
      else line_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Empty line, trailing separator, quote pair with newline close, lone quote
  // in an unclosed quoted field, and padded content with extreme byte values.
  task automatic test_directed_lines();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(cft_pkg::KIND_EOL, 8'hFF);
    send_text("a,");
    send_text("\"q\"\"r\"\n");
    send_text("\"a\"b");
    line_q = '{8'h09, 8'h00, 8'h20, 8'hFF, 8'h0D, sep_byte, 8'h78};
    send_line();
    wait_drain();
  endtask

  // A field cut past the length limit, then an inner blank run past the limit.
  task automatic test_long_fields();
    line_q.delete();
    line_q.push_back(8'h61);
    repeat (cft_pkg::FIELD_MAX + 3) line_q.push_back(8'h41 + 8'($urandom_range(25)));
    line_q.push_back(sep_byte);
    line_q.push_back(8'h63);
    repeat (cft_pkg::FIELD_MAX + 2) line_q.push_back(pick_blank());
    line_q.push_back(8'h64);
    send_line();
    wait_drain();
  endtask

  // More fields than the cap; the tail of the line is ignored.
  task automatic test_field_cap();
    line_q.delete();
    for (int f = 0; f < cft_pkg::MAX_FIELDS + 2; f++) begin
      line_q.push_back(8'h6B);
      line_q.push_back(sep_byte);
    end
    send_line();
    wait_drain();
  endtask

  // Extreme and odd delimiter choices, including one byte for both.
  task automatic test_register_settings();
    logic [cft_pkg::BYTE_W-1:0] seps [5];
    logic [cft_pkg::BYTE_W-1:0] quotes [5];
    seps   = '{8'h00, 8'hFF, 8'h20, 8'h7C, cft_pkg::NEWLINE};
    quotes = '{8'hFF, 8'h00, 8'h27, 8'h7C, 8'h22};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (seps[i]) begin
      set_delimiters(seps[i], quotes[i]);
      repeat (2) begin
        build_random_line(3);
        send_line();
      end
      wait_drain();
    end
    set_delimiters(cft_pkg::SEP_RESET, cft_pkg::QUOTE_RESET);
  endtask

  // Sender idle, receiver stalling, then both.
  task automatic test_idle_mixes();
    int unsigned send_mix [3];
    int unsigned stall_mix [3];
    send_mix  = '{81, 0, 24};
    stall_mix = '{0, 81, 24};
    foreach (send_mix[i]) begin
      send_idle_pct = send_mix[i];
      stall_pct     = stall_mix[i];
      repeat (2) begin
        build_random_line(3);
        send_line();
      end
      wait_drain();
    end
  endtask

  // Long output hold-off while the sender keeps offering items.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = HOLD_STRETCH;
    repeat (3) begin
      build_random_line(4);
      send_line();
    end
    wait_drain();
  endtask

  task automatic test_noise_lines();
    send_idle_pct = 24;
    stall_pct     = 24;
    repeat (4) begin
      build_noise_line();
      send_line();
    end
    send_item(cft_pkg::KIND_EOL, 8'h00);
    wait_drain();
  endtask

  initial begin
    reset_tokenizer();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lines();
    test_long_fields();
    test_field_cap();
    test_register_settings();
    test_idle_mixes();
    test_backpressure();
    test_noise_lines();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d items in %0d lines and checked %0d results, %0d register writes.",
             items_sent, lines_sent, results_seen, cfg_writes);
    $display("Phases: directed, overlong, field cap, delimiter sets, idle mixes, hold-off, noise.");
    if (mismatches == 0) begin
      $display("tb_csv_field_tokenizer_core: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_csv_field_tokenizer_core: FAIL");
    end
    $finish;
  end

endmodule
